>>> hw/rtl/cfs_pkg.sv
// shared constants, types and register codes of the 3x3 convolution filter
`default_nettype none

package cfs_pkg;

  // sizing
  localparam int MAX_SIDE   = 1024;
  localparam int PIXEL_BITS = 8;
  localparam int ADDR_BITS  = $clog2(MAX_SIDE);
  localparam int SIDE_BITS  = 11;
  localparam int CMP_BITS   = (SIDE_BITS > ADDR_BITS + 1) ? SIDE_BITS : ADDR_BITS + 1;
  localparam int POS_BITS   = 10;
  localparam int OUT_BITS   = 16;
  localparam int TAP_BITS   = 7;
  localparam int NUM_TAPS   = 9;
  localparam int TAPS_BITS  = TAP_BITS * NUM_TAPS;
  localparam int CFG_IDX_BITS = 1;

  // configuration defaults
  localparam logic [SIDE_BITS-1:0] SIDE_RESET = SIDE_BITS'(5);
  localparam int MIN_SIDE = 3;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_SIDE  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_TAPS = 1'b1;

  // arithmetic widths
  localparam int PROD_BITS  = PIXEL_BITS + TAP_BITS + 1;
  localparam int SUM_BITS   = PROD_BITS + 4;
  localparam int ABS_BITS   = PIXEL_BITS + 10;
  localparam int DIV_SHIFT  = ABS_BITS + 3;
  localparam int MUL_BITS   = DIV_SHIFT - 2;
  localparam int QUO_BITS   = ABS_BITS - 2;
  localparam int CLAMP_BITS = (QUO_BITS + 1 > OUT_BITS + 1) ? QUO_BITS + 1 : OUT_BITS + 1;

  // reciprocal of 7, exact for every magnitude below 2**ABS_BITS
  localparam logic [MUL_BITS-1:0] DIV7_MUL =
    MUL_BITS'(((64'd1 << DIV_SHIFT) + 64'd6) / 64'd7);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [NUM_TAPS-1:0][PIXEL_BITS-1:0] window_t;

  // position tags that travel with one result
  typedef struct packed {
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                last;
  } meta_t;

endpackage

`default_nettype wire

>>> hw/rtl/cfs_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module cfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cfs_window.sv
// position counters, two line stores and the 3x3 pixel window
`default_nettype none

module cfs_window (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [cfs_pkg::PIXEL_BITS-1:0] in_pixel,
  input  logic                         in_frame_start,
  input  logic [cfs_pkg::CMP_BITS-1:0] side_eff,
  output logic                         win_valid,
  output cfs_pkg::window_t             win_pixels,
  output cfs_pkg::meta_t               win_meta
);

  localparam int AB = cfs_pkg::ADDR_BITS;
  localparam int CB = cfs_pkg::CMP_BITS;

  logic [AB-1:0] row_r, col_r, row_nxt, col_nxt;
  logic [CB-1:0] r0, c0, r1, c1, r2, cn, rn;
  logic [AB-1:0] pos_r, pos_c;
  logic          emit;
  cfs_pkg::meta_t meta;

  // stage 1 registers
  logic            s1_valid_r;
  cfs_pkg::pix_t   s1_px_r;
  logic [AB-1:0]   s1_col_r;
  logic            s1_emit_r;
  cfs_pkg::meta_t  s1_meta_r;

  // bypass of the write that collides with the read
  logic            fwd_hit_r;
  cfs_pkg::pix_t   fwd_up_r, fwd_mid_r;

  cfs_pkg::pix_t   up_rd, mid_rd, top, mid;
  cfs_pkg::window_t win_r, win_nxt;
  logic            win_valid_r;
  cfs_pkg::meta_t  win_meta_r;
  logic            wr_en;

  // position of the incoming pixel and of the next one
  always_comb begin
    r0 = in_frame_start ? '0 : CB'(row_r);
    c0 = in_frame_start ? '0 : CB'(col_r);
    if (c0 >= side_eff) begin
      c1 = '0;
      r1 = r0 + 1'b1;
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2 = (r1 >= side_eff) ? '0 : r1;
    pos_r = r2[AB-1:0];
    pos_c = c1[AB-1:0];

    cn = c1 + 1'b1;
    rn = r2 + 1'b1;
    if (cn >= side_eff) begin
      col_nxt = '0;
      row_nxt = (rn >= side_eff) ? '0 : rn[AB-1:0];
    end else begin
      col_nxt = cn[AB-1:0];
      row_nxt = pos_r;
    end

    emit      = (r2 >= CB'(2)) && (c1 >= CB'(2));
    meta.row  = cfs_pkg::POS_BITS'(pos_r - 1'b1);
    meta.col  = cfs_pkg::POS_BITS'(pos_c - 1'b1);
    meta.last = (r2 == side_eff - 1'b1) && (c1 == side_eff - 1'b1);
  end

  // counters move on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (adv && in_valid) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  // stage 1 payload and bypass
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r   <= in_pixel;
      s1_col_r  <= pos_c;
      s1_emit_r <= emit;
      s1_meta_r <= meta;
      fwd_hit_r <= s1_valid_r && (s1_col_r == pos_c);
      fwd_up_r  <= mid;
      fwd_mid_r <= s1_px_r;
    end
  end

  // line stores: read at accept, written from stage 1 on the next advance
  assign wr_en = s1_valid_r && adv;

  cfs_ram #(
    .WIDTH(cfs_pkg::PIXEL_BITS),
    .DEPTH(cfs_pkg::MAX_SIDE)
  ) u_upper (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(s1_col_r),
    .wr_data(mid),
    .rd_en  (adv),
    .rd_addr(pos_c),
    .rd_data(up_rd)
  );

  cfs_ram #(
    .WIDTH(cfs_pkg::PIXEL_BITS),
    .DEPTH(cfs_pkg::MAX_SIDE)
  ) u_middle (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(s1_col_r),
    .wr_data(s1_px_r),
    .rd_en  (adv),
    .rd_addr(pos_c),
    .rd_data(mid_rd)
  );

  assign top = fwd_hit_r ? fwd_up_r  : up_rd;
  assign mid = fwd_hit_r ? fwd_mid_r : mid_rd;

  // shift window left, new column on the right
  always_comb begin
    win_nxt = win_r;
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3]     = win_r[k*3+1];
      win_nxt[k*3 + 1] = win_r[k*3+2];
    end
    win_nxt[2] = top;
    win_nxt[5] = mid;
    win_nxt[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      win_valid_r <= 1'b0;
    end else if (adv) begin
      if (s1_valid_r) begin
        win_r <= win_nxt;
      end
      win_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      win_meta_r <= s1_meta_r;
    end
  end

  assign win_valid  = win_valid_r;
  assign win_pixels = win_r;
  assign win_meta   = win_meta_r;

endmodule

`default_nettype wire

>>> hw/rtl/cfs_mac.sv
// tap products, window sum, divide by seven and result register
`default_nettype none

module cfs_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic                          win_valid,
  input  cfs_pkg::window_t              win_pixels,
  input  cfs_pkg::meta_t                win_meta,
  input  logic [cfs_pkg::TAPS_BITS-1:0] taps,
  output logic                          res_valid,
  output logic signed [cfs_pkg::OUT_BITS-1:0] res_value,
  output cfs_pkg::meta_t                res_meta
);

  localparam int PB = cfs_pkg::PROD_BITS;
  localparam int SB = cfs_pkg::SUM_BITS;
  localparam int AB = cfs_pkg::ABS_BITS;
  localparam int QB = cfs_pkg::QUO_BITS;
  localparam int KB = cfs_pkg::CLAMP_BITS;
  localparam logic signed [KB-1:0] SAT_HI = KB'((2 ** (cfs_pkg::OUT_BITS - 1)) - 1);
  localparam logic signed [KB-1:0] SAT_LO = -SAT_HI - 1'b1;

  // stage a: products
  logic                 a_valid_r;
  logic signed [PB-1:0] prod_r [cfs_pkg::NUM_TAPS];
  logic signed [PB-1:0] prod_nxt [cfs_pkg::NUM_TAPS];
  cfs_pkg::meta_t       a_meta_r;

  // stage b: magnitude and sign of the sum
  logic                 b_valid_r, b_neg_r;
  logic [AB-1:0]        b_abs_r;
  cfs_pkg::meta_t       b_meta_r;
  logic signed [SB-1:0] sum;
  logic [SB-1:0]        mag;

  // stage c: quotient magnitude
  logic                 c_valid_r, c_neg_r;
  logic [QB-1:0]        c_quo_r;
  cfs_pkg::meta_t       c_meta_r;
  logic [AB+cfs_pkg::MUL_BITS-1:0] full;

  // result
  logic signed [KB-1:0] sval;
  logic signed [cfs_pkg::OUT_BITS-1:0] val_nxt;
  logic                 res_valid_r;
  logic signed [cfs_pkg::OUT_BITS-1:0] res_value_r;
  cfs_pkg::meta_t       res_meta_r;

  // nine signed products
  always_comb begin
    for (int t = 0; t < cfs_pkg::NUM_TAPS; t++) begin
      prod_nxt[t] = PB'($signed({1'b0, win_pixels[t]})) *
                    PB'($signed(taps[cfs_pkg::TAP_BITS*t +: cfs_pkg::TAP_BITS]));
    end
  end

  // sum and magnitude
  always_comb begin
    sum = '0;
    for (int t = 0; t < cfs_pkg::NUM_TAPS; t++) begin
      sum = sum + SB'(prod_r[t]);
    end
    mag = sum[SB-1] ? SB'(-sum) : SB'(sum);
  end

  // reciprocal multiply
  assign full = b_abs_r * cfs_pkg::DIV7_MUL;

  // restore sign and saturate
  always_comb begin
    sval = c_neg_r ? -KB'({1'b0, c_quo_r}) : KB'({1'b0, c_quo_r});
    if (sval > SAT_HI) begin
      val_nxt = cfs_pkg::OUT_BITS'(SAT_HI);
    end else if (sval < SAT_LO) begin
      val_nxt = cfs_pkg::OUT_BITS'(SAT_LO);
    end else begin
      val_nxt = cfs_pkg::OUT_BITS'(sval);
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= win_valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      res_valid_r <= c_valid_r;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r      <= prod_nxt;
      a_meta_r    <= win_meta;
      b_abs_r     <= mag[AB-1:0];
      b_neg_r     <= sum[SB-1];
      b_meta_r    <= a_meta_r;
      c_quo_r     <= full[cfs_pkg::DIV_SHIFT +: QB];
      c_neg_r     <= b_neg_r;
      c_meta_r    <= b_meta_r;
      res_value_r <= val_nxt;
      res_meta_r  <= c_meta_r;
    end
  end

  assign res_valid = res_valid_r;
  assign res_value = res_value_r;
  assign res_meta  = res_meta_r;

endmodule

`default_nettype wire

>>> hw/rtl/conv3x3_stream_filter.sv
// top level of the streaming 3x3 convolution filter
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  input    | in_valid / in_stall | in_pixel, in_frame_start
//  result   | out_valid/out_stall | out_filtered_value, out_row, out_col,
//           |                     | out_frame_last
//  config   | cfg_wr_en           | cfg_index, cfg_data
//
// one pixel per clock unless a held result stalls; a result passes the stage 1,
// window, a, b, c and result registers; the pace is set by the two line-store rams,
// read in the accept cycle and written from stage 1 on the next advance, with a
// bypass for back-to-back hits on one column; synchronous reset clears counters,
// window, pipeline valids and registers; the line stores keep their contents;
// a held result freezes the whole pipeline and raises in_stall in the same cycle
`default_nettype none

module conv3x3_stream_filter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cfs_pkg::PIXEL_BITS-1:0]       in_pixel,
  input  logic                                 in_frame_start,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cfs_pkg::OUT_BITS-1:0] out_filtered_value,
  output logic [cfs_pkg::POS_BITS-1:0]         out_row,
  output logic [cfs_pkg::POS_BITS-1:0]         out_col,
  output logic                                 out_frame_last,
  input  logic                                 cfg_wr_en,
  input  logic [cfs_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [cfs_pkg::TAPS_BITS-1:0]        cfg_data
);

  localparam int CB = cfs_pkg::CMP_BITS;

  logic [cfs_pkg::SIDE_BITS-1:0] side_r, side_nxt;
  logic [cfs_pkg::TAPS_BITS-1:0] taps_r, taps_nxt;
  logic [CB-1:0]                 side_ext, side_eff;
  logic                          adv;
  logic                          win_valid;
  cfs_pkg::window_t              win_pixels;
  cfs_pkg::meta_t                win_meta, res_meta;

  // configuration writes
  always_comb begin
    side_nxt = side_r;
    taps_nxt = taps_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        cfs_pkg::CFG_IMAGE_SIDE:  side_nxt = cfg_data[cfs_pkg::SIDE_BITS-1:0];
        cfs_pkg::CFG_KERNEL_TAPS: taps_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= cfs_pkg::SIDE_RESET;
      taps_r <= '0;
    end else begin
      side_r <= side_nxt;
      taps_r <= taps_nxt;
    end
  end

  // side clamped to the supported range
  always_comb begin
    side_ext = CB'(side_r);
    if (side_ext < CB'(cfs_pkg::MIN_SIDE)) begin
      side_eff = CB'(cfs_pkg::MIN_SIDE);
    end else if (side_ext > CB'(cfs_pkg::MAX_SIDE)) begin
      side_eff = CB'(cfs_pkg::MAX_SIDE);
    end else begin
      side_eff = side_ext;
    end
  end

  // pipeline moves unless a finished result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  cfs_window u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .in_pixel      (in_pixel),
    .in_frame_start(in_frame_start),
    .side_eff      (side_eff),
    .win_valid     (win_valid),
    .win_pixels    (win_pixels),
    .win_meta      (win_meta)
  );

  cfs_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .win_valid (win_valid),
    .win_pixels(win_pixels),
    .win_meta  (win_meta),
    .taps      (taps_r),
    .res_valid (out_valid),
    .res_value (out_filtered_value),
    .res_meta  (res_meta)
  );

  assign out_row        = res_meta.row;
  assign out_col        = res_meta.col;
  assign out_frame_last = res_meta.last;

  // the last result of a frame sits on the diagonal
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |-> out_row == out_col)
    else $error("frame_last off the diagonal");

  // results only for interior positions
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row != '0 && out_col != '0)
    else $error("result on a border position");

  // quotient stays within the reachable range of 7-bit taps
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_filtered_value >= -16'sd20982 && out_filtered_value <= 16'sd20655)
    else $error("filtered value out of range");

endmodule

`default_nettype wire
